// ----- rtl/core/oal_pkg.sv -----
// Shared types and codes for the ordered array list engine.
package oal_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [1:0] CMD_INS_AT   = 2'd0;
  localparam logic [1:0] CMD_INS_SORT = 2'd1;
  localparam logic [1:0] CMD_DEL_AT   = 2'd2;
  localparam logic [1:0] CMD_LOCATE   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_INVALID   = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] location;
    logic [4:0] list_count;
  } out_item_t;

  typedef struct packed {
    logic               shift_up;
    logic               shift_down;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// ----- rtl/core/oal_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors, compares against the key.
module oal_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  oal_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      tgt,
  input  logic signed [31:0] prev_data,
  input  logic signed [31:0] next_data,
  output logic signed [31:0] data,
  output logic               lt,
  output logic               eq
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_up) begin
      if (MY_IDX > tgt) begin
        data_nxt = prev_data;
      end else if (MY_IDX == tgt) begin
        data_nxt = ctl.value;
      end
    end else if (ctl.shift_down) begin
      if (MY_IDX >= tgt) begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign lt   = data_r < ctl.value;
  assign eq   = data_r == ctl.value;

endmodule

// ----- rtl/core/ordered_array_list_engine.sv -----
// Top level of the ordered array list engine: command sequencer over a chain of list cells.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+-----------------------------------------
//   command  | start, busy, in_item   | transaction taken when start && !busy
//   result   | out_valid, out_item    | one-cycle strobe, one per command
//
// Cycles: a rejected command answers in the cycle right after it is taken.
// Insert at position and delete at position pass through decode, then shift.
// Sorted insert and locate walk the key past one cell per cycle; the scan counter
// over the cell chain steps the key along until a hit or the end of the list.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// entry contents are not cleared. The receiver cannot stall: every result
// shows for exactly one cycle, and busy is already low while it shows.
module ordered_array_list_engine #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oal_pkg::in_item_t  in_item,
  output logic               out_valid,
  output oal_pkg::out_item_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int WW = (CW > 5) ? CW : 5;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [CW-1:0]      tgt_r, tgt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  oal_pkg::out_item_t out_item_r, out_item_nxt;

  oal_pkg::cell_ctl_t ctl;
  logic signed [31:0] data_vec [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;

  logic [WW-1:0] pos_w;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] cnt_nxt_w;
  logic [WW-1:0] loc_w;
  logic          full;
  logic          scan_end;
  logic          hit;

  // Cell chain: each cell sees its left and right neighbor; the ends see themselves.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] prev_d;
    logic signed [31:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = data_vec[g];
    end else begin : g_mid_l
      assign prev_d = data_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_d = data_vec[g];
    end else begin : g_mid_r
      assign next_d = data_vec[g+1];
    end
    oal_cell #(.CW(CW), .IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .tgt       (tgt_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (data_vec[g]),
      .lt        (lt_vec[g]),
      .eq        (eq_vec[g])
    );
  end

  // Shift only during the apply cycle; the key is broadcast to every cell.
  always_comb begin
    ctl.value      = value_r;
    ctl.shift_up   = (state_r == S_APPLY) && (cmd_r != oal_pkg::CMD_DEL_AT);
    ctl.shift_down = (state_r == S_APPLY) && (cmd_r == oal_pkg::CMD_DEL_AT);
  end

  assign pos_w    = WW'(in_item.position);
  assign cnt_w    = WW'(count_r);
  assign full     = count_r == CW'(CAPACITY);
  assign scan_end = idx_r == count_r;
  // Locate stops on the first equal entry, sorted insert on the first one not smaller.
  assign hit      = (cmd_r == oal_pkg::CMD_LOCATE) ? eq_vec[idx_r[IW-1:0]]
                                                   : !lt_vec[idx_r[IW-1:0]];
  assign loc_w    = WW'(idx_r) + WW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    tgt_nxt       = tgt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    cnt_nxt_w     = cnt_w;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt                 = in_item.cmd;
          value_nxt               = in_item.value;
          idx_nxt                 = '0;
          out_item_nxt.location   = '0;
          out_item_nxt.list_count = cnt_w[4:0];
          case (in_item.cmd)
            oal_pkg::CMD_INS_AT: begin
              if (pos_w > cnt_w) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = oal_pkg::STAT_INVALID;
              end else if (full) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = oal_pkg::STAT_FULL;
              end else begin
                tgt_nxt   = pos_w[CW-1:0];
                state_nxt = S_APPLY;
              end
            end
            oal_pkg::CMD_INS_SORT: begin
              if (full) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = oal_pkg::STAT_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            oal_pkg::CMD_DEL_AT: begin
              if (pos_w >= cnt_w) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = oal_pkg::STAT_INVALID;
              end else begin
                tgt_nxt   = pos_w[CW-1:0];
                state_nxt = S_APPLY;
              end
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_end || hit) begin
          if (cmd_r == oal_pkg::CMD_LOCATE) begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.list_count = cnt_w[4:0];
            state_nxt               = S_IDLE;
            if (scan_end) begin
              out_item_nxt.status   = oal_pkg::STAT_NOT_FOUND;
              out_item_nxt.location = '0;
            end else begin
              out_item_nxt.status   = oal_pkg::STAT_OK;
              out_item_nxt.location = loc_w[4:0];
            end
          end else begin
            tgt_nxt   = idx_r;
            state_nxt = S_APPLY;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      S_APPLY: begin
        if (cmd_r == oal_pkg::CMD_DEL_AT) begin
          count_nxt = count_r - CW'(1);
        end else begin
          count_nxt = count_r + CW'(1);
        end
        cnt_nxt_w               = WW'(count_nxt);
        out_valid_nxt           = 1'b1;
        out_item_nxt.status     = oal_pkg::STAT_OK;
        out_item_nxt.location   = '0;
        out_item_nxt.list_count = cnt_nxt_w[4:0];
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the command and result payload; no reset needed.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    value_r    <= value_nxt;
    tgt_r      <= tgt_nxt;
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/oal_checker.sv -----
// Port-level checks for the ordered array list engine, bound to the top level.
module oal_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input oal_pkg::out_item_t out_item
);

  // Reset leaves the engine idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("engine not idle after reset");

  // A taken transaction either starts work or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction produced neither work nor a result");

  // A result marks the end of its command.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // Only a successful locate reports a location.
  a_location_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.location != 5'd0 |-> out_item.status == oal_pkg::STAT_OK)
    else $error("location reported with a failing status");

endmodule

bind ordered_array_list_engine oal_checker u_oal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- sim/ordered_array_list_engine_tb.sv -----
// Self-checking testbench for the ordered array list engine.
module ordered_array_list_engine_tb;

  localparam int CAPACITY      = oal_pkg::CAPACITY_DEF;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1420;
  localparam int QUIET_FIRST   = 500;   // random items in [QUIET_FIRST, QUIET_LAST) never idle
  localparam int QUIET_LAST    = 800;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = CAPACITY + 8;
  localparam int LIMIT_CYCLES  = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  oal_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  oal_pkg::out_item_t out_item;

  ordered_array_list_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the list: contents and fill level after every accepted command.
  logic signed [31:0] list_vals [CAPACITY];
  int                 list_len = 0;

  // Replies still owed by the block, oldest first.
  oal_pkg::out_item_t pending_replies [$];

  // Directed script: a row either carries a hand-written reply or defers to the shadow list.
  typedef struct {
    oal_pkg::in_item_t  cmd_item;
    bit                 typed;
    oal_pkg::out_item_t reply;
  } script_row_t;

  script_row_t script [$];

  int  fail_count = 0;
  int  results_checked = 0;
  int  cmd_seen [4] = '{0, 0, 0, 0};
  int  status_seen [4] = '{0, 0, 0, 0};
  int  peak_len = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  oal_pkg::out_item_t want_reply;

  // Apply one command to the shadow list and return the reply it must produce.
  function automatic oal_pkg::out_item_t apply_list_command(oal_pkg::in_item_t c);
    oal_pkg::out_item_t r;
    int                 slot;
    int                 i;
    r.status   = oal_pkg::STAT_OK;
    r.location = '0;
    case (c.cmd)
      oal_pkg::CMD_INS_AT, oal_pkg::CMD_INS_SORT: begin
        // Position range is checked ahead of the full check; sorted insert has no position.
        if (c.cmd == oal_pkg::CMD_INS_AT && int'(c.position) > list_len) begin
          r.status = oal_pkg::STAT_INVALID;
        end else if (list_len >= CAPACITY) begin
          r.status = oal_pkg::STAT_FULL;
        end else begin
          slot = int'(c.position);
          if (c.cmd == oal_pkg::CMD_INS_SORT) begin
            slot = 0;
            while (slot < list_len && list_vals[slot] < c.value) slot++;
          end
          for (i = list_len; i > slot; i--) list_vals[i] = list_vals[i - 1];
          list_vals[slot] = c.value;
          list_len++;
        end
      end
      oal_pkg::CMD_DEL_AT: begin
        if (int'(c.position) >= list_len) begin
          r.status = oal_pkg::STAT_INVALID;
        end else begin
          for (i = int'(c.position); i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
        end
      end
      default: begin
        r.status = oal_pkg::STAT_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_vals[i] == c.value) begin
            r.status   = oal_pkg::STAT_OK;
            r.location = 5'(i + 1);
            break;
          end
        end
      end
    endcase
    r.list_count = 5'(list_len);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic signed [31:0] value, logic [4:0] pos,
                                  bit typed, logic [1:0] status, logic [4:0] loc,
                                  logic [4:0] count);
    script_row_t row;
    row.cmd_item.cmd      = cmd;
    row.cmd_item.value    = value;
    row.cmd_item.position = pos;
    row.typed             = typed;
    row.reply.status      = status;
    row.reply.location    = loc;
    row.reply.list_count  = count;
    script.push_back(row);
  endfunction

  // Build the directed script: empty-list errors, value extremes, a fill to capacity,
  // the full and out-of-range rejects on a full list, then deletes at both ends.
  function automatic void build_script();
    int k;
    add_row(oal_pkg::CMD_LOCATE, 32'sd5, 5'd0, 1'b1, oal_pkg::STAT_NOT_FOUND, 5'd0, 5'd0);
    add_row(oal_pkg::CMD_DEL_AT, 32'sd0, 5'd0, 1'b1, oal_pkg::STAT_INVALID, 5'd0, 5'd0);
    add_row(oal_pkg::CMD_INS_AT, 32'sd1, 5'd1, 1'b1, oal_pkg::STAT_INVALID, 5'd0, 5'd0);
    add_row(oal_pkg::CMD_INS_AT, 32'sh7FFFFFFF, 5'd0, 1'b1, oal_pkg::STAT_OK, 5'd0, 5'd1);
    add_row(oal_pkg::CMD_INS_SORT, 32'sh80000000, 5'd0, 1'b1, oal_pkg::STAT_OK, 5'd0, 5'd2);
    add_row(oal_pkg::CMD_LOCATE, 32'sh80000000, 5'd0, 1'b1, oal_pkg::STAT_OK, 5'd1, 5'd2);
    add_row(oal_pkg::CMD_INS_SORT, 32'sd0, 5'd31, 1'b0, oal_pkg::STAT_OK, 5'd0, 5'd0);
    // Append at the tail (position equal to count) leaves the list out of order.
    add_row(oal_pkg::CMD_INS_AT, -32'sd1, 5'd3, 1'b0, oal_pkg::STAT_OK, 5'd0, 5'd0);
    add_row(oal_pkg::CMD_INS_AT, 32'sd9, 5'd31, 1'b1, oal_pkg::STAT_INVALID, 5'd0, 5'd4);
    add_row(oal_pkg::CMD_DEL_AT, 32'sd0, 5'd31, 1'b1, oal_pkg::STAT_INVALID, 5'd0, 5'd4);
    // Duplicate key, then locate must report the first copy.
    add_row(oal_pkg::CMD_INS_SORT, 32'sd0, 5'd0, 1'b0, oal_pkg::STAT_OK, 5'd0, 5'd0);
    add_row(oal_pkg::CMD_LOCATE, 32'sd0, 5'd0, 1'b0, oal_pkg::STAT_OK, 5'd0, 5'd0);
    for (k = 0; k < CAPACITY - 5; k++) begin
      add_row(k[0] ? oal_pkg::CMD_INS_SORT : oal_pkg::CMD_INS_AT, 32'(k * 1000 - 5000),
              5'(k % 3), 1'b0, oal_pkg::STAT_OK, 5'd0, 5'd0);
    end
    add_row(oal_pkg::CMD_INS_AT, 32'sd3, 5'd16, 1'b1, oal_pkg::STAT_FULL, 5'd0, 5'd16);
    add_row(oal_pkg::CMD_INS_SORT, 32'sd3, 5'd0, 1'b1, oal_pkg::STAT_FULL, 5'd0, 5'd16);
    add_row(oal_pkg::CMD_INS_AT, 32'sd3, 5'd17, 1'b1, oal_pkg::STAT_INVALID, 5'd0, 5'd16);
    add_row(oal_pkg::CMD_DEL_AT, 32'sd0, 5'd16, 1'b1, oal_pkg::STAT_INVALID, 5'd0, 5'd16);
    add_row(oal_pkg::CMD_DEL_AT, 32'sd0, 5'd15, 1'b1, oal_pkg::STAT_OK, 5'd0, 5'd15);
    add_row(oal_pkg::CMD_DEL_AT, 32'sd0, 5'd0, 1'b1, oal_pkg::STAT_OK, 5'd0, 5'd14);
    add_row(oal_pkg::CMD_LOCATE, 32'sh7FFFFFFF, 5'd0, 1'b0, oal_pkg::STAT_OK, 5'd0, 5'd0);
  endfunction

  // Draw a random command. Most are well formed against the current list (legal
  // positions, keys that are present); a slice is raw noise over every field value.
  function automatic oal_pkg::in_item_t random_command(int grow_pct);
    oal_pkg::in_item_t c;
    int                pick;
    c.cmd      = oal_pkg::CMD_LOCATE;
    c.value    = $urandom;
    c.position = 5'($urandom_range(31, 0));
    if ($urandom_range(99, 0) < 12) begin
      c.cmd = 2'($urandom_range(3, 0));
      return c;
    end
    // Small keys collide often, extremes probe the signed ordering.
    case ($urandom_range(3, 0))
      0: c.value = 32'($urandom_range(16, 0)) - 32'd8;
      1: c.value = $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: ;
    endcase
    pick = $urandom_range(99, 0);
    if (pick < grow_pct) begin
      c.cmd      = $urandom_range(1, 0) ? oal_pkg::CMD_INS_AT : oal_pkg::CMD_INS_SORT;
      c.position = 5'($urandom_range(list_len, 0));
    end else if (pick < grow_pct + (100 - grow_pct) / 2) begin
      c.cmd      = oal_pkg::CMD_DEL_AT;
      c.position = (list_len > 0) ? 5'($urandom_range(list_len - 1, 0)) : 5'd0;
    end else begin
      c.cmd = oal_pkg::CMD_LOCATE;
      if (list_len > 0 && $urandom_range(3, 0) != 0) begin
        c.value = list_vals[$urandom_range(list_len - 1, 0)];
      end
    end
    return c;
  endfunction

  // Offer one command, hold it until the transaction is taken, then log the owed reply.
  // Busy is read right after the edge, so it is the value the block saw at that edge.
  task automatic send_command(input oal_pkg::in_item_t c, input bit typed,
                              input oal_pkg::out_item_t reply);
    oal_pkg::out_item_t predicted;
    start   <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_list_command(c);
    pending_replies.push_back(typed ? reply : predicted);
    cmd_seen[c.cmd]++;
    if (list_len > peak_len) peak_len = list_len;
    // Drop start now and then, so gaps land in every phase of the block's work.
    if (idle_on && $urandom_range(99, 0) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Hold the sender off until every owed reply has come back.
  task automatic wait_for_empty();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Check each result strobe against the oldest owed reply, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_checked++;
      status_seen[out_item.status]++;
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing pending: status %0d location %0d count %0d",
                 $time, out_item.status, out_item.location, out_item.list_count);
        fail_count++;
      end else begin
        want_reply = pending_replies.pop_front();
        if (out_item.status !== want_reply.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want_reply.status, out_item.status);
          fail_count++;
        end
        if (out_item.location !== want_reply.location) begin
          $display("%0t: location mismatch: expected %0d, actual %0d",
                   $time, want_reply.location, out_item.location);
          fail_count++;
        end
        if (out_item.list_count !== want_reply.list_count) begin
          $display("%0t: list_count mismatch: expected %0d, actual %0d",
                   $time, want_reply.list_count, out_item.list_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d replies still owed",
               cycle_count, pending_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int grow_pct;
    int drain;
    build_script();

    // Hold reset for a fixed stretch, then release it once for the whole run.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the script, typed rows carry their own reply.
    for (k = 0; k < script.size(); k++) begin
      send_command(script[k].cmd_item, script[k].typed, script[k].reply);
    end
    wait_for_empty();

    // Random part: alternate growth-heavy and shrink-heavy stretches so the list
    // swings between empty and full, with a quiet stretch that never idles.
    grow_pct = 75;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 150 == 0) grow_pct = (grow_pct == 75) ? 30 : 75;
      idle_on = !(k >= QUIET_FIRST && k < QUIET_LAST);
      if (k > 0 && k % 400 == 0) wait_for_empty();
      send_command(random_command(grow_pct), 1'b0, '0);
    end
    start <= 1'b0;

    // Drain the owed replies, then give the block time to show anything stray.
    drain = 0;
    while (pending_replies.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      fail_count += pending_replies.size();
    end

    $display("Run: %0d insert-at, %0d sorted insert, %0d delete, %0d locate; %0d results checked",
             cmd_seen[oal_pkg::CMD_INS_AT], cmd_seen[oal_pkg::CMD_INS_SORT],
             cmd_seen[oal_pkg::CMD_DEL_AT], cmd_seen[oal_pkg::CMD_LOCATE], results_checked);
    $display("Outcomes: %0d ok, %0d bad position, %0d full, %0d miss; list peaked at %0d",
             status_seen[oal_pkg::STAT_OK], status_seen[oal_pkg::STAT_INVALID],
             status_seen[oal_pkg::STAT_FULL], status_seen[oal_pkg::STAT_NOT_FOUND], peak_len);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/oal_pkg.sv
rtl/core/oal_cell.sv
rtl/core/ordered_array_list_engine.sv
rtl/core/oal_checker.sv
sim/ordered_array_list_engine_tb.sv
